FILE: rtl/uee_pkg.sv
package uee_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_EDGES    = 256;
   localparam int VIDX_W       = 8;
   localparam int KEY_W        = 2 * VIDX_W;
   localparam int CNT_W        = 9;
   localparam int COORD_W      = 32;
   localparam int POS_W        = 3 * COORD_W;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_ADD   = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              ins;
      logic [KEY_W-1:0]  key;
      logic              clr;
   } cell_cmd_type;

   function automatic logic [COORD_W-1:0] sat_sub(input logic [COORD_W-1:0] hi,
                                                  input logic [COORD_W-1:0] lo);
      logic [COORD_W:0] d;
      d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
      if (d[COORD_W] != d[COORD_W-1])
         sat_sub = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      else
         sat_sub = d[COORD_W-1:0];
   endfunction

endpackage

FILE: rtl/uee_ram.sv
module uee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/uee_cell.sv
module uee_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  uee_pkg::cell_cmd_type     cmd,
   input  logic                      prev_occ,
   input  logic                      prev_lt,
   input  logic [uee_pkg::KEY_W-1:0] prev_key,
   output logic                      occ,
   output logic                      lt,
   output logic                      hit,
   output logic [uee_pkg::KEY_W-1:0] key
);
   logic                      occ_ff;
   logic [uee_pkg::KEY_W-1:0] key_ff;

   assign occ = occ_ff;
   assign key = key_ff;
   // occupied and smaller than the key being inserted
   assign lt  = occ_ff && (key_ff < cmd.key);
   assign hit = occ_ff && (key_ff == cmd.key);

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         occ_ff <= 1'b0;
      end else if (cmd.ins && !lt) begin
         if (prev_lt) begin
            occ_ff <= 1'b1;
            key_ff <= cmd.key;
         end else if (prev_occ) begin
            occ_ff <= 1'b1;
            key_ff <= prev_key;
         end
      end
   end
endmodule

FILE: rtl/unique_edge_extractor.sv
// unique edge extractor
// req_ channel carries one command per transfer: clear the edge table, load a
// vertex position, add the edges of a triangle, or read one edge slot.
// rsp_ channel returns exactly one result per command, in order.
// edges live in a row of 256 cells kept sorted; an insert shifts the larger
// cells up one place at once, so a triangle takes three insert steps, one per
// edge, and then presents the result. clear and load go straight to the
// result state. read does the vertex store read of both ends, then the
// saturated subtract, then presents the result. the next command can be
// taken in the cycle after the result transfer.
// vertex positions sit in two ram copies (one per edge end) which a clearing
// pass over all 256 entries zeroes after reset; no command is taken during it.
// one item is worked on at a time; req_stall is high while busy or while a
// result waits. when the receiver stalls, the result holds on rsp_ unchanged.
module unique_edge_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_index_a,
   input  logic [7:0]  req_index_b,
   input  logic [7:0]  req_index_c,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_edge_count,
   output logic        rsp_edge_valid,
   output logic [7:0]  rsp_lower_vertex,
   output logic [7:0]  rsp_higher_vertex,
   output logic [31:0] rsp_delta_x,
   output logic [31:0] rsp_delta_y,
   output logic [31:0] rsp_delta_z,
   output logic        rsp_table_full
);
   localparam int KW = uee_pkg::KEY_W;
   localparam int VW = uee_pkg::VIDX_W;
   localparam int NE = uee_pkg::MAX_EDGES;
   localparam int CW = uee_pkg::COORD_W;

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_INS  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_DIF  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [VW-1:0]         sweep_ff, sweep_in;
   logic [1:0]            step_ff, step_in;
   logic [VW-1:0]         ia_ff, ib_ff, ic_ff;
   logic [uee_pkg::CNT_W-1:0] count_ff, count_in;
   logic                  full_ff, full_in;
   logic                  ev_ff, ev_in;
   logic [VW-1:0]         lo_ff, lo_in, hi_ff, hi_in;

   uee_pkg::cell_cmd_type cmd;
   logic [NE-1:0]         occ, lt, hit;
   logic [KW-1:0]         ckey [NE];

   // current edge of the triangle
   logic [VW-1:0] p, q, elo, ehi;
   always_comb begin
      unique case (step_ff)
         2'd0:    begin p = ia_ff; q = ib_ff; end
         2'd1:    begin p = ib_ff; q = ic_ff; end
         default: begin p = ic_ff; q = ia_ff; end
      endcase
      elo = (p < q) ? p : q;
      ehi = (p < q) ? q : p;
   end

   logic accept, out_take, is_dup, tbl_full;
   assign accept   = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign is_dup   = |hit;
   assign tbl_full = count_ff[uee_pkg::CNT_W-1];

   always_comb begin
      cmd.key = {elo, ehi};
      cmd.ins = (state_ff == ST_INS) && !is_dup && !tbl_full;
      cmd.clr = accept && (req_opcode == uee_pkg::OP_CLEAR);
   end

   genvar g;
   generate
      for (g = 0; g < NE; g++) begin : g_cell
         if (g == 0) begin : g_first
            uee_cell u_cell (.clock, .reset, .cmd, .prev_occ(1'b1), .prev_lt(1'b1),
               .prev_key({KW{1'b0}}), .occ(occ[g]), .lt(lt[g]), .hit(hit[g]),
               .key(ckey[g]));
         end else begin : g_rest
            uee_cell u_cell (.clock, .reset, .cmd, .prev_occ(occ[g-1]),
               .prev_lt(lt[g-1]), .prev_key(ckey[g-1]), .occ(occ[g]), .lt(lt[g]),
               .hit(hit[g]), .key(ckey[g]));
         end
      end
   endgenerate

   // vertex store, one copy per edge end
   logic                    vwr;
   logic [VW-1:0]           vaddr;
   logic [uee_pkg::POS_W-1:0] vdata, rd_lo, rd_hi;
   assign vwr   = (state_ff == ST_INIT) || (accept && req_opcode == uee_pkg::OP_LOAD);
   assign vaddr = (state_ff == ST_INIT) ? sweep_ff : req_index_a;
   assign vdata = (state_ff == ST_INIT) ? '0 : {req_pos_x, req_pos_y, req_pos_z};

   uee_ram #(.WIDTH(uee_pkg::POS_W), .DEPTH(uee_pkg::MAX_VERTICES)) u_vlo (
      .clock, .wr_en(vwr), .wr_addr(vaddr), .wr_data(vdata), .rd_addr(lo_ff),
      .rd_data(rd_lo));
   uee_ram #(.WIDTH(uee_pkg::POS_W), .DEPTH(uee_pkg::MAX_VERTICES)) u_vhi (
      .clock, .wr_en(vwr), .wr_addr(vaddr), .wr_data(vdata), .rd_addr(hi_ff),
      .rd_data(rd_hi));

   logic [CW-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      step_in  = step_ff;
      count_in = count_ff;
      full_in  = full_ff;
      ev_in    = ev_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;
      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == VW'(uee_pkg::MAX_VERTICES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               full_in = 1'b0;
               ev_in   = 1'b0;
               lo_in   = '0;
               hi_in   = '0;
               dx_in   = '0;
               dy_in   = '0;
               dz_in   = '0;
               step_in = '0;
               unique case (req_opcode)
                  uee_pkg::OP_CLEAR: begin count_in = '0; state_in = ST_OUT; end
                  uee_pkg::OP_LOAD:  state_in = ST_OUT;
                  uee_pkg::OP_ADD:   state_in = ST_INS;
                  default: begin
                     if ({1'b0, req_index_a} < count_ff) begin
                        ev_in = 1'b1;
                        lo_in = ckey[req_index_a][KW-1:VW];
                        hi_in = ckey[req_index_a][VW-1:0];
                     end
                     state_in = ST_RD;
                  end
               endcase
            end
         end
         ST_INS: begin
            if (!is_dup) begin
               if (tbl_full) full_in = 1'b1;
               else count_in = count_ff + 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd2) state_in = ST_OUT;
         end
         ST_RD: state_in = ST_DIF;
         ST_DIF: begin
            if (ev_ff) begin
               dx_in = uee_pkg::sat_sub(rd_hi[3*CW-1:2*CW], rd_lo[3*CW-1:2*CW]);
               dy_in = uee_pkg::sat_sub(rd_hi[2*CW-1:CW], rd_lo[2*CW-1:CW]);
               dz_in = uee_pkg::sat_sub(rd_hi[CW-1:0], rd_lo[CW-1:0]);
            end
            state_in = ST_OUT;
         end
         ST_OUT: if (out_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         count_ff <= count_in;
      end
      step_ff <= step_in;
      full_ff <= full_in;
      ev_ff   <= ev_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      if (accept) begin
         ia_ff <= req_index_a;
         ib_ff <= req_index_b;
         ic_ff <= req_index_c;
      end
   end

   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_edge_count    = count_ff;
   assign rsp_edge_valid    = ev_ff;
   assign rsp_lower_vertex  = lo_ff;
   assign rsp_higher_vertex = hi_ff;
   assign rsp_delta_x       = dx_ff;
   assign rsp_delta_y       = dy_ff;
   assign rsp_delta_z       = dz_ff;
   assign rsp_table_full    = full_ff;
endmodule
